/* hdl/urt_pkg.sv */
// ----------------------------------------------------------------------------
// urt_pkg
// Shared widths, codes and controller/datapath interface types for the
// user role table.
// ----------------------------------------------------------------------------
package urt_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned ROLE_W    = 2;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [ROLE_W-1:0] GUEST_ROLE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the input transaction
    logic compare;   // register the per-entry hit vector
    logic encode;    // register the first hit position
    logic exec;      // perform the operation, compute the result
    logic move;      // copy the last entry into the removed slot
    logic load_out;  // load the output register
  } urt_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [ACTION_W-1:0] op;
    logic                found;
  } urt_sts_t;

endpackage

/* hdl/urt_ctrl.sv */
// ----------------------------------------------------------------------------
// urt_ctrl
// Sequencer for the user role table: runs compare, encode, execute and move
// as each action needs them, and owns the output valid flag.
// ----------------------------------------------------------------------------
module urt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  urt_pkg::urt_sts_t sts_i,
  output urt_pkg::urt_cmd_t cmd_o
);
  import urt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_EXEC,
    S_MOVE,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        // add and the unused code need no search
        if (sts_i.op == ACT_REMOVE || sts_i.op == ACT_LOOKUP) begin
          cmd_o.compare = 1'b1;
          state_d       = S_ENC;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_ENC: begin
        cmd_o.encode = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op == ACT_REMOVE && sts_i.found) begin
          state_d = S_MOVE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CMP))
    else $error("accepted transaction did not start the sequence");
  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("output register overwritten while full");
  a_move_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (sts_i.found && sts_i.op == ACT_REMOVE))
    else $error("move without a matching remove");
`endif

endmodule

/* hdl/urt_datapath.sv */
// ----------------------------------------------------------------------------
// urt_datapath
// Register table of ids and roles with parallel id compare, first-hit
// encoder, swap-with-last removal and the output register.
// ----------------------------------------------------------------------------
module urt_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [urt_pkg::ACTION_W-1:0]      action_i,
  input  logic [urt_pkg::ID_W-1:0]          user_id_i,
  input  logic [urt_pkg::ROLE_W-1:0]        role_in_i,
  output logic [urt_pkg::ROLE_W-1:0]        role_out_o,
  output logic                              matched_o,
  output logic                              add_rejected_o,
  output logic [urt_pkg::CNT_OUT_W-1:0]     entries_used_o,
  input  urt_pkg::urt_cmd_t                 cmd_i,
  output urt_pkg::urt_sts_t                 sts_o
);
  import urt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  logic [ID_W-1:0]     entry_id_q   [TABLE_DEPTH];
  logic [ROLE_W-1:0]   entry_role_q [TABLE_DEPTH];
  logic [CNT_W-1:0]    count_q;

  logic [ACTION_W-1:0] op_q;
  logic [ID_W-1:0]     id_q;
  logic [ROLE_W-1:0]   role_q;

  logic [TABLE_DEPTH-1:0] hit_q;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic                found_q;

  logic [ID_W-1:0]     mv_id_q;
  logic [ROLE_W-1:0]   mv_role_q;

  logic [ROLE_W-1:0]   res_role_q;
  logic                res_match_q;
  logic                res_rej_q;

  logic [ROLE_W-1:0]   out_role_q;
  logic                out_match_q;
  logic                out_rej_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  logic                full;
  logic [IDX_W-1:0]    tail_idx;
  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic                do_add;

  assign full     = (count_q == CNT_FULL);
  assign tail_idx = count_q[IDX_W-1:0];
  assign last_cnt = count_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign do_add   = cmd_i.exec && (op_q == ACT_ADD) && !full;

  assign sts_o.op    = op_q;
  assign sts_o.found = found_q;

  // first hit wins
  always_comb begin
    pos_d = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (hit_q[k]) begin
        pos_d = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_add) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.move) begin
      count_q <= last_cnt;
    end
  end

  // table write port: append on add, swap-in of the last entry on remove
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      entry_id_q[tail_idx]   <= id_q;
      entry_role_q[tail_idx] <= role_q;
    end else if (cmd_i.move) begin
      entry_id_q[pos_q]   <= mv_id_q;
      entry_role_q[pos_q] <= mv_role_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= action_i;
      id_q   <= user_id_i;
      role_q <= (role_in_i > GUEST_ROLE) ? GUEST_ROLE : role_in_i;
    end
    if (cmd_i.compare) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        hit_q[k] <= (CNT_W'(k) < count_q) && (entry_id_q[k] == id_q);
      end
    end
    if (cmd_i.encode) begin
      pos_q   <= pos_d;
      found_q <= |hit_q;
    end
    if (cmd_i.exec) begin
      res_role_q  <= GUEST_ROLE;
      res_match_q <= 1'b0;
      res_rej_q   <= 1'b0;
      unique case (op_q)
        ACT_ADD: begin
          res_rej_q <= full;
        end
        ACT_REMOVE: begin
          res_match_q <= found_q;
          mv_id_q     <= entry_id_q[last_idx];
          mv_role_q   <= entry_role_q[last_idx];
        end
        ACT_LOOKUP: begin
          res_match_q <= found_q;
          if (found_q) begin
            res_role_q <= entry_role_q[pos_q];
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_role_q  <= res_role_q;
      out_match_q <= res_match_q;
      out_rej_q   <= res_rej_q;
      out_cnt_q   <= CNT_OUT_W'(count_q);
    end
  end

  assign role_out_o     = out_role_q;
  assign matched_o      = out_match_q;
  assign add_rejected_o = out_rej_q;
  assign entries_used_o = out_cnt_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count above table depth");
  a_move_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |=> (count_q == $past(last_cnt)))
    else $error("remove did not shrink the count");
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_add |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("add did not grow the count");
`endif

endmodule

/* hdl/user_role_table_unit.sv */
// ----------------------------------------------------------------------------
// user_role_table_unit
// Associative table of user ids to roles with add, swap-remove and lookup.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o | action_i, user_id_i, role_in_i
//  out     | out_valid_o/out_stall_i | role_out_o, matched_o, add_rejected_o,
//          |                         | entries_used_o
//
//  one transaction at a time, sequenced by the controller: add and the unused
//  code skip the search; lookup runs the compare stage, first-hit encode and
//  table read, and remove the same plus the move write on a hit
//  the output register frees the input side, a waiting result only holds the
//  next transaction in its final step until the result is taken
//  reset clears the entry count and control state, the table needs no clear
// ----------------------------------------------------------------------------
module user_role_table_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [urt_pkg::ACTION_W-1:0]  action_i,
  input  logic [urt_pkg::ID_W-1:0]      user_id_i,
  input  logic [urt_pkg::ROLE_W-1:0]    role_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [urt_pkg::ROLE_W-1:0]    role_out_o,
  output logic                          matched_o,
  output logic                          add_rejected_o,
  output logic [urt_pkg::CNT_OUT_W-1:0] entries_used_o
);
  import urt_pkg::*;

  urt_cmd_t cmd;
  urt_sts_t sts;

  urt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  urt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .user_id_i      (user_id_i),
    .role_in_i      (role_in_i),
    .role_out_o     (role_out_o),
    .matched_o      (matched_o),
    .add_rejected_o (add_rejected_o),
    .entries_used_o (entries_used_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks user_role_table_unit against a cycle-free model of the id/role table.
// A directed sequence covers id extremes, every action, role code 3, removal
// from the middle, the front and the last slot, and removal or lookup on an
// empty table. It is followed by random add-heavy and remove-heavy phases
// that fill and drain the table, with random idling on both channels and one
// long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import urt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_OPS  = 600;
  localparam int unsigned ID_POOL_SZ  = 24;
  localparam int unsigned IDLE_PCT    = 21;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [ROLE_W-1:0]   ADMIN_ROLE = 2'd0;
  localparam logic [ROLE_W-1:0]   USER_ROLE  = 2'd1;
  localparam logic [ROLE_W-1:0]   ROLE_BAD   = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     user_id;
    logic [ROLE_W-1:0]   role;
  } table_op_t;

  typedef struct packed {
    logic [ROLE_W-1:0]    role_out;
    logic                 matched;
    logic                 add_rejected;
    logic [CNT_OUT_W-1:0] entries_used;
  } table_reply_t;

  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [ACTION_W-1:0]  action    = '0;
  logic [ID_W-1:0]      user_id   = '0;
  logic [ROLE_W-1:0]    role_in   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROLE_W-1:0]    role_out;
  logic                 matched;
  logic                 add_rejected;
  logic [CNT_OUT_W-1:0] entries_used;

  table_op_t    pending_ops[$];
  table_reply_t replies_due[$];

  // predictor state
  logic [ID_W-1:0]   tbl_id   [TABLE_DEPTH];
  logic [ROLE_W-1:0] tbl_role [TABLE_DEPTH];
  int unsigned       tbl_count = 0;

  int unsigned ops_sent     = 0;
  int unsigned replies_seen = 0;
  int unsigned error_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  user_role_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .user_id_i     (user_id),
    .role_in_i     (role_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .role_out_o    (role_out),
    .matched_o     (matched),
    .add_rejected_o(add_rejected),
    .entries_used_o(entries_used)
  );

  always #1 clk = ~clk;

  // apply one operation to the predicted table and return its reply
  function automatic table_reply_t apply_table_op(input table_op_t op);
    table_reply_t      r;
    logic [ROLE_W-1:0] role;
    int                hit;
    r    = '{role_out: GUEST_ROLE, matched: 1'b0, add_rejected: 1'b0, entries_used: '0};
    role = (op.role == ROLE_BAD) ? GUEST_ROLE : op.role;
    hit  = -1;
    for (int k = 0; k < tbl_count; k++) begin
      if (hit < 0 && tbl_id[k] == op.user_id) hit = k;
    end
    case (op.action)
      ACT_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.add_rejected = 1'b1;
        end else begin
          tbl_id[tbl_count]   = op.user_id;
          tbl_role[tbl_count] = role;
          tbl_count++;
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          // swap-remove: the last entry fills the hole
          tbl_id[hit]   = tbl_id[tbl_count-1];
          tbl_role[hit] = tbl_role[tbl_count-1];
          tbl_count--;
          r.matched = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          r.role_out = tbl_role[hit];
          r.matched  = 1'b1;
        end
      end
      default: ;
    endcase
    r.entries_used = tbl_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  function automatic table_op_t make_op(input logic [ACTION_W-1:0] a, input logic [ID_W-1:0] id,
                                        input logic [ROLE_W-1:0] r);
    make_op = '{action: a, user_id: id, role: r};
  endfunction

  // driver
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(apply_table_op('{action: action, user_id: user_id, role: role_in}));
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        // no idling while the no-gap stretch runs
        if (pending_ops.size() != 0 &&
            ((ops_sent >= 200 && ops_sent < 350) || $urandom_range(99) >= IDLE_PCT)) begin
          table_op_t op;
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          action   <= op.action;
          user_id  <= op.user_id;
          role_in  <= op.role;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected transaction, role_out %0d matched %0d rejected %0d used %0d",
                   $time, role_out, matched, add_rejected, entries_used);
          error_count++;
        end else begin
          table_reply_t exp_r;
          exp_r = replies_due.pop_front();
          check_field("role_out", exp_r.role_out, role_out);
          check_field("matched", exp_r.matched, matched);
          check_field("add_rejected", exp_r.add_rejected, add_rejected);
          check_field("entries_used", exp_r.entries_used, entries_used);
        end
      end
      // long hold-off so the block backs up into its input
      if (!hold_done && replies_seen == 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (replies_seen >= 200 && replies_seen < 350) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [ID_W-1:0] id_pool[ID_POOL_SZ];
    logic [ID_W-1:0] id;
    logic [ACTION_W-1:0] act;
    int unsigned r;
    bit fill_phase;

    // directed: extremes, duplicates, role code 3, the unused action
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'h0000, ADMIN_ROLE));  // empty table
    pending_ops.push_back(make_op(ACT_REMOVE, 16'hFFFF, ADMIN_ROLE));  // empty table
    pending_ops.push_back(make_op(ACT_ADD,    16'hFFFF, ADMIN_ROLE));
    pending_ops.push_back(make_op(ACT_ADD,    16'h0000, USER_ROLE));
    pending_ops.push_back(make_op(ACT_ADD,    16'hFFFF, ROLE_BAD));    // duplicate, stored as guest
    pending_ops.push_back(make_op(ACT_ADD,    16'hA5A5, GUEST_ROLE));
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'hFFFF, ROLE_BAD));
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'h0000, ADMIN_ROLE));
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'h5A5A, USER_ROLE));   // miss
    pending_ops.push_back(make_op(ACT_UNUSED, 16'hFFFF, ROLE_BAD));
    pending_ops.push_back(make_op(ACT_REMOVE, 16'h0000, ROLE_BAD));    // middle slot
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'hA5A5, ADMIN_ROLE));
    pending_ops.push_back(make_op(ACT_REMOVE, 16'h5A5A, ADMIN_ROLE));  // absent id
    pending_ops.push_back(make_op(ACT_REMOVE, 16'hFFFF, ADMIN_ROLE));  // front slot
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'hFFFF, ADMIN_ROLE));  // second copy found
    pending_ops.push_back(make_op(ACT_REMOVE, 16'hFFFF, ADMIN_ROLE));  // front slot again
    pending_ops.push_back(make_op(ACT_REMOVE, 16'hA5A5, ADMIN_ROLE));  // last entry
    pending_ops.push_back(make_op(ACT_LOOKUP, 16'hA5A5, ADMIN_ROLE));
    pending_ops.push_back(make_op(ACT_UNUSED, 16'h0000, ADMIN_ROLE));

    // random: small id pool so removes and lookups hit, phases fill and drain
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int k = 2; k < ID_POOL_SZ; k++) id_pool[k] = ID_W'($urandom);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      fill_phase = ((n / 50) % 2) == 0;
      r = $urandom_range(99);
      if (fill_phase) begin
        act = (r < 60) ? ACT_ADD : (r < 80) ? ACT_LOOKUP : (r < 95) ? ACT_REMOVE : ACT_UNUSED;
      end else begin
        act = (r < 15) ? ACT_ADD : (r < 45) ? ACT_LOOKUP : (r < 95) ? ACT_REMOVE : ACT_UNUSED;
      end
      id = ($urandom_range(9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(ID_POOL_SZ-1)];
      pending_ops.push_back(make_op(act, id, ROLE_W'($urandom_range(3))));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
